// ----- hw/rtl/chap_pkg.sv -----
// shared types, codes and transition table of the chap control machine
package chap_pkg;

  // input function codes
  localparam logic [3:0] FN_AUTH_BOTH   = 4'd0;
  localparam logic [3:0] FN_AUTH_REMOTE = 4'd1;
  localparam logic [3:0] FN_AUTH_LOCAL  = 4'd2;
  localparam logic [3:0] FN_FORCE       = 4'd3;
  localparam logic [3:0] FN_CLOSE       = 4'd4;
  localparam logic [3:0] FN_RX_CHAL     = 4'd5;
  localparam logic [3:0] FN_RX_SUCC     = 4'd6;
  localparam logic [3:0] FN_RX_FAIL     = 4'd7;
  localparam logic [3:0] FN_RX_RESP     = 4'd8;
  localparam logic [3:0] FN_TICK        = 4'd9;

  // table rows
  localparam logic [3:0] EV_AUTH_BOTH   = 4'd0;
  localparam logic [3:0] EV_AUTH_REMOTE = 4'd1;
  localparam logic [3:0] EV_AUTH_LOCAL  = 4'd2;
  localparam logic [3:0] EV_RX_CHAL     = 4'd3;
  localparam logic [3:0] EV_RX_SUCC     = 4'd4;
  localparam logic [3:0] EV_RX_FAIL     = 4'd5;
  localparam logic [3:0] EV_GOOD_RESP   = 4'd6;
  localparam logic [3:0] EV_BAD_RESP    = 4'd7;
  localparam logic [3:0] EV_RTO_PLUS    = 4'd8;
  localparam logic [3:0] EV_RTO_MINUS   = 4'd9;
  localparam logic [3:0] EV_CTO_PLUS    = 4'd10;
  localparam logic [3:0] EV_CTO_MINUS   = 4'd11;
  localparam logic [3:0] EV_FORCE       = 4'd12;
  localparam logic [3:0] EV_CLOSE       = 4'd13;
  localparam int unsigned NUM_EV = 14;

  // machine states
  localparam logic [3:0] ST_C0  = 4'd0;
  localparam logic [3:0] ST_C1  = 4'd1;
  localparam logic [3:0] ST_C2  = 4'd2;
  localparam logic [3:0] ST_C3  = 4'd3;
  localparam logic [3:0] ST_C4  = 4'd4;
  localparam logic [3:0] ST_C5  = 4'd5;
  localparam logic [3:0] ST_C6  = 4'd6;
  localparam logic [3:0] ST_C7  = 4'd7;
  localparam logic [3:0] ST_C8  = 4'd8;
  localparam logic [3:0] ST_C9  = 4'd9;
  localparam logic [3:0] ST_C10 = 4'd10;
  localparam logic [3:0] ST_C11 = 4'd11;
  localparam int unsigned NUM_ST = 12;

  // actions
  localparam logic [3:0] ACT_NONE   = 4'd0;
  localparam logic [3:0] ACT_SRCIRC = 4'd1;
  localparam logic [3:0] ACT_SRRIRR = 4'd2;
  localparam logic [3:0] ACT_SRS    = 4'd3;
  localparam logic [3:0] ACT_SRSAAS = 4'd4;
  localparam logic [3:0] ACT_SRFRAF = 4'd5;
  localparam logic [3:0] ACT_AAS    = 4'd6;
  localparam logic [3:0] ACT_LAF    = 4'd7;
  localparam logic [3:0] ACT_RAF    = 4'd8;
  localparam logic [3:0] ACT_SRR    = 4'd9;
  localparam logic [3:0] ACT_SRC    = 4'd10;

  // configuration register indexes
  localparam logic REG_MAX_RESTARTS  = 1'b0;
  localparam logic REG_RESTART_TICKS = 1'b1;

  localparam logic [7:0]  MAX_RESTARTS_RST  = 8'd10;
  localparam logic [15:0] RESTART_TICKS_RST = 16'd3000;

  localparam logic [7:0] TE_X = 8'hFF;

  function automatic logic [7:0] te(input logic [3:0] act, input logic [3:0] st);
    return {act, st};
  endfunction

  localparam logic [7:0] TRANS [NUM_EV][NUM_ST] = '{
    '{te(ACT_SRCIRC, ST_C6), TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X,
      TE_X, TE_X},
    '{te(ACT_SRCIRC, ST_C4), TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X,
      TE_X, TE_X},
    '{te(ACT_NONE, ST_C1), TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X, TE_X,
      TE_X, TE_X},
    '{TE_X, te(ACT_SRRIRR, ST_C2), te(ACT_SRRIRR, ST_C2), te(ACT_SRRIRR, ST_C2),
      TE_X, TE_X, te(ACT_SRRIRR, ST_C8), te(ACT_SRRIRR, ST_C9),
      te(ACT_SRRIRR, ST_C8), te(ACT_SRRIRR, ST_C9), te(ACT_SRRIRR, ST_C8),
      te(ACT_SRRIRR, ST_C9)},
    '{TE_X, TE_X, te(ACT_AAS, ST_C3), TE_X, TE_X, TE_X, TE_X, TE_X,
      te(ACT_NONE, ST_C10), te(ACT_AAS, ST_C11), TE_X, TE_X},
    '{TE_X, TE_X, te(ACT_LAF, ST_C0), TE_X, TE_X, TE_X, TE_X, TE_X,
      te(ACT_LAF, ST_C0), te(ACT_LAF, ST_C0), TE_X, TE_X},
    '{TE_X, TE_X, TE_X, TE_X, te(ACT_SRSAAS, ST_C5), te(ACT_SRS, ST_C5),
      te(ACT_SRS, ST_C7), te(ACT_SRS, ST_C7), te(ACT_SRS, ST_C9), te(ACT_SRS, ST_C9),
      te(ACT_SRSAAS, ST_C11), te(ACT_SRS, ST_C11)},
    '{TE_X, TE_X, TE_X, TE_X, te(ACT_SRFRAF, ST_C0), te(ACT_SRFRAF, ST_C0),
      te(ACT_SRFRAF, ST_C0), te(ACT_SRFRAF, ST_C0), te(ACT_SRFRAF, ST_C0),
      te(ACT_SRFRAF, ST_C0), te(ACT_SRFRAF, ST_C0), te(ACT_SRFRAF, ST_C0)},
    '{TE_X, te(ACT_NONE, ST_C1), te(ACT_SRR, ST_C2), TE_X, TE_X, TE_X,
      te(ACT_NONE, ST_C6), te(ACT_NONE, ST_C7), te(ACT_SRR, ST_C8),
      te(ACT_SRR, ST_C9), TE_X, TE_X},
    '{TE_X, te(ACT_LAF, ST_C0), te(ACT_LAF, ST_C2), TE_X, TE_X, TE_X,
      te(ACT_LAF, ST_C0), te(ACT_LAF, ST_C0), te(ACT_LAF, ST_C0), te(ACT_LAF, ST_C0),
      te(ACT_LAF, ST_C0), TE_X},
    '{TE_X, TE_X, TE_X, TE_X, te(ACT_SRC, ST_C4), TE_X, te(ACT_SRC, ST_C6), TE_X,
      te(ACT_SRC, ST_C8), TE_X, te(ACT_SRC, ST_C10), TE_X},
    '{TE_X, TE_X, TE_X, TE_X, te(ACT_RAF, ST_C0), TE_X, te(ACT_RAF, ST_C0), TE_X,
      te(ACT_RAF, ST_C0), TE_X, te(ACT_RAF, ST_C10), TE_X},
    '{TE_X, TE_X, TE_X, TE_X, te(ACT_SRCIRC, ST_C4), te(ACT_SRCIRC, ST_C4),
      te(ACT_SRCIRC, ST_C6), te(ACT_SRCIRC, ST_C6), te(ACT_SRCIRC, ST_C8),
      te(ACT_SRCIRC, ST_C8), te(ACT_SRCIRC, ST_C8), te(ACT_SRCIRC, ST_C10)},
    '{te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0),
      te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0),
      te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0),
      te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0), te(ACT_NONE, ST_C0)}
  };

  function automatic logic [7:0] trans_lookup(input logic [3:0] ev, input logic [3:0] st);
    logic [7:0] e;
    e = TE_X;
    if (ev < 4'(NUM_EV) && st < 4'(NUM_ST)) begin
      e = TRANS[ev][st];
    end
    return e;
  endfunction

  typedef enum logic [2:0] {
    K_EVENT,
    K_RX_CHAL,
    K_RX_SUCC,
    K_RX_FAIL,
    K_RX_RESP,
    K_TICK,
    K_UNDEF
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [3:0] ev;
    logic [7:0] pkt_id;
    logic       good;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  fsm_state;
    logic        send_challenge;
    logic        send_response;
    logic        send_success;
    logic        send_failure;
    logic        report_success;
    logic        report_local_fail;
    logic        report_remote_fail;
    logic [7:0]  challenge_id;
    logic [7:0]  response_id;
    logic        ignored;
  } result_t;

  typedef struct packed {
    logic        we;
    logic        idx;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [3:0] fsm_state;
    logic       chall_on;
    logic       resp_on;
  } back_status_t;

endpackage

// ----- hw/rtl/chap_front.sv -----
// front end: input handshake and classification of each event
module chap_front import chap_pkg::*; (
  input  logic       s_valid_i,
  input  logic [3:0] func_i,
  input  logic [7:0] pkt_id_i,
  input  logic       response_good_i,
  input  logic       q_full_i,
  output logic       s_ready_o,
  output logic       push_o,
  output cmd_t       cmd_o
);

  assign s_ready_o = ~q_full_i;
  assign push_o    = s_valid_i & ~q_full_i;

  always_comb begin
    cmd_o.pkt_id = pkt_id_i;
    cmd_o.good   = response_good_i;
    cmd_o.ev     = EV_AUTH_BOTH;
    cmd_o.kind   = K_UNDEF;
    case (func_i)
      FN_AUTH_BOTH: begin
        cmd_o.kind = K_EVENT;
        cmd_o.ev   = EV_AUTH_BOTH;
      end
      FN_AUTH_REMOTE: begin
        cmd_o.kind = K_EVENT;
        cmd_o.ev   = EV_AUTH_REMOTE;
      end
      FN_AUTH_LOCAL: begin
        cmd_o.kind = K_EVENT;
        cmd_o.ev   = EV_AUTH_LOCAL;
      end
      FN_FORCE: begin
        cmd_o.kind = K_EVENT;
        cmd_o.ev   = EV_FORCE;
      end
      FN_CLOSE: begin
        cmd_o.kind = K_EVENT;
        cmd_o.ev   = EV_CLOSE;
      end
      FN_RX_CHAL: cmd_o.kind = K_RX_CHAL;
      FN_RX_SUCC: cmd_o.kind = K_RX_SUCC;
      FN_RX_FAIL: cmd_o.kind = K_RX_FAIL;
      FN_RX_RESP: cmd_o.kind = K_RX_RESP;
      FN_TICK:    cmd_o.kind = K_TICK;
      default:    cmd_o.kind = K_UNDEF;
    endcase
  end

endmodule

// ----- hw/rtl/chap_queue.sv -----
// short command queue between front end and back end
module chap_queue import chap_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hw/rtl/chap_back.sv -----
// back end: id checks, timers, table lookup and result register
module chap_back import chap_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_wr_t      cfg_i,
  input  logic         q_valid_i,
  input  cmd_t         cmd_i,
  output logic         pop_o,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  output result_t      res_o,
  output back_status_t status_o
);

  logic [7:0]  max_q;
  logic [15:0] ticks_q;
  logic [3:0]  fsm_q, fsm_d;
  logic [7:0]  cid_q, cid_d, rid_q, rid_d;
  logic [7:0]  crt_q, crt_d, rrt_q, rrt_d;
  logic [15:0] ctm_q, ctm_d, rtm_q, rtm_d;
  logic        con_q, con_d, ron_q, ron_d;
  logic        out_vld_q;
  result_t     res_q, res_d;

  logic        run;
  logic [3:0]  ev;
  logic [7:0]  entry;
  logic [3:0]  act, ns;
  logic        cexp, rexp;

  assign pop_o     = q_valid_i & (~out_vld_q | m_ready_i);
  assign m_valid_o = out_vld_q;
  assign res_o     = res_q;
  assign status_o  = '{fsm_state: fsm_q, chall_on: con_q, resp_on: ron_q};

  assign cexp  = con_q & (ctm_q <= 16'd1);
  assign rexp  = ron_q & (rtm_q <= 16'd1);

  always_comb begin
    fsm_d = fsm_q;
    cid_d = cid_q;
    rid_d = rid_q;
    crt_d = crt_q;
    rrt_d = rrt_q;
    ctm_d = ctm_q;
    rtm_d = rtm_q;
    con_d = con_q;
    ron_d = ron_q;
    res_d = '0;
    run   = 1'b0;
    ev    = cmd_i.ev;
    entry = TE_X;
    act   = ACT_NONE;
    ns    = fsm_q;

    case (cmd_i.kind)
      K_EVENT: run = 1'b1;
      K_RX_CHAL: begin
        rid_d = cmd_i.pkt_id;
        ev    = EV_RX_CHAL;
        run   = 1'b1;
      end
      K_RX_SUCC: begin
        ev = EV_RX_SUCC;
        if (cmd_i.pkt_id != rid_q) res_d.ignored = 1'b1;
        else run = 1'b1;
      end
      K_RX_FAIL: begin
        ev = EV_RX_FAIL;
        if (cmd_i.pkt_id != rid_q) res_d.ignored = 1'b1;
        else run = 1'b1;
      end
      K_RX_RESP: begin
        ev = cmd_i.good ? EV_GOOD_RESP : EV_BAD_RESP;
        if (cmd_i.pkt_id != cid_q) res_d.ignored = 1'b1;
        else run = 1'b1;
      end
      K_TICK: begin
        if (cexp) begin
          if (crt_q != 8'd0) begin
            ctm_d = ticks_q;
            ev    = EV_CTO_PLUS;
          end else begin
            con_d = 1'b0;
            ev    = EV_CTO_MINUS;
          end
          if (ron_q && !rexp) rtm_d = rtm_q - 16'd1;
          run = 1'b1;
        end else if (rexp) begin
          if (rrt_q != 8'd0) begin
            rtm_d = ticks_q;
            ev    = EV_RTO_PLUS;
          end else begin
            ron_d = 1'b0;
            ev    = EV_RTO_MINUS;
          end
          if (con_q) ctm_d = ctm_q - 16'd1;
          run = 1'b1;
        end else begin
          if (con_q) ctm_d = ctm_q - 16'd1;
          if (ron_q) rtm_d = rtm_q - 16'd1;
        end
      end
      default: res_d.ignored = 1'b1;
    endcase

    if (run) begin
      entry = trans_lookup(ev, fsm_q);
      act   = entry[7:4];
      ns    = entry[3:0];
      if (entry == TE_X) begin
        res_d.ignored = 1'b1;
      end else begin
        // send challenge / send response side effects
        if (act == ACT_SRCIRC || act == ACT_SRC) begin
          cid_d = cid_d + 8'd1;
          res_d.send_challenge = 1'b1;
          if (crt_d != 8'd0) crt_d = crt_d - 8'd1;
        end
        if (act == ACT_SRRIRR || act == ACT_SRR) begin
          res_d.send_response = 1'b1;
          if (rrt_d != 8'd0) rrt_d = rrt_d - 8'd1;
        end
        if (act == ACT_SRCIRC) begin
          crt_d = max_q;
          ctm_d = ticks_q;
          con_d = 1'b1;
        end
        if (act == ACT_SRRIRR) begin
          rrt_d = max_q;
          rtm_d = ticks_q;
          ron_d = 1'b1;
        end
        res_d.send_success      = (act == ACT_SRS) || (act == ACT_SRSAAS);
        res_d.send_failure      = (act == ACT_SRFRAF);
        res_d.report_success    = (act == ACT_SRSAAS) || (act == ACT_AAS);
        res_d.report_local_fail = (act == ACT_LAF);
        res_d.report_remote_fail = (act == ACT_SRFRAF) || (act == ACT_RAF);
        fsm_d = ns;
        if (ns == ST_C0 || ns == ST_C1 || ns == ST_C2 || ns == ST_C3 || ns == ST_C5 ||
            ns == ST_C7 || ns == ST_C9 || ns == ST_C11) begin
          con_d = 1'b0;
        end
        if (ns == ST_C0 || ns == ST_C3 || ns == ST_C4 || ns == ST_C5 || ns == ST_C10 ||
            ns == ST_C11) begin
          ron_d = 1'b0;
        end
      end
    end

    res_d.fsm_state    = fsm_d;
    res_d.challenge_id = cid_d;
    res_d.response_id  = rid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q     <= MAX_RESTARTS_RST;
      ticks_q   <= RESTART_TICKS_RST;
      fsm_q     <= ST_C0;
      cid_q     <= '0;
      rid_q     <= '0;
      crt_q     <= '0;
      rrt_q     <= '0;
      ctm_q     <= '0;
      rtm_q     <= '0;
      con_q     <= 1'b0;
      ron_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          REG_MAX_RESTARTS:  max_q   <= cfg_i.data[7:0];
          REG_RESTART_TICKS: ticks_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (pop_o) begin
        fsm_q <= fsm_d;
        cid_q <= cid_d;
        rid_q <= rid_d;
        crt_q <= crt_d;
        rrt_q <= rrt_d;
        ctm_q <= ctm_d;
        rtm_q <= rtm_d;
        con_q <= con_d;
        ron_q <= ron_d;
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- hw/rtl/chap_authentication_fsm.sv -----
// top level of the chap authentication control machine
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser func, tdata pkt_id, response_good
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata state, actions, ids; tuser ignored
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// one event per cycle sustained while the output is not stalled; a result passes through
// the queue stage, then the result register in the back end
// the back end executes one queued event per cycle, limited by the result register
// reset clears state, ids, timers and the queue; registers return to 10 and 3000
// a stalled output holds the back end; the queue keeps taking input until full
module chap_authentication_fsm import chap_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // pkt_id[7:0], response_good[8], zero[15:9]
  input  logic [3:0]  s_axis_tuser,  // func[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_state[3:0], send_challenge[4], send_response[5], send_success[6],
  // send_failure[7], report_success[8], report_local_fail[9],
  // report_remote_fail[10], challenge_id[18:11], response_id[26:19], zero[31:27]
  output logic [31:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,  // ignored[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t         f_cmd, q_cmd;
  logic         f_push, q_full, q_valid, b_pop;
  cfg_wr_t      cfg_wr;
  result_t      res;
  back_status_t b_status;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = '{we: cfg_valid_i, idx: cfg_index_i, data: cfg_data_i};

  chap_front u_front (
    .s_valid_i       (s_axis_tvalid),
    .func_i          (s_axis_tuser),
    .pkt_id_i        (s_axis_tdata[7:0]),
    .response_good_i (s_axis_tdata[8]),
    .q_full_i        (q_full),
    .s_ready_o       (s_axis_tready),
    .push_o          (f_push),
    .cmd_o           (f_cmd)
  );

  chap_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_cmd),
    .full_o  (q_full),
    .pop_i   (b_pop),
    .valid_o (q_valid),
    .data_o  (q_cmd)
  );

  chap_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_wr),
    .q_valid_i (q_valid),
    .cmd_i     (q_cmd),
    .pop_o     (b_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res),
    .status_o  (b_status)
  );

  assign m_axis_tdata = {5'd0, res.response_id, res.challenge_id, res.report_remote_fail,
                         res.report_local_fail, res.report_success, res.send_failure,
                         res.send_success, res.send_response, res.send_challenge,
                         res.fsm_state};
  assign m_axis_tuser = res.ignored;

`ifndef SYNTHESIS
  a_chall_timer_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.chall_on |-> !(b_status.fsm_state == ST_C0 || b_status.fsm_state == ST_C1 ||
      b_status.fsm_state == ST_C2 || b_status.fsm_state == ST_C3 ||
      b_status.fsm_state == ST_C5 || b_status.fsm_state == ST_C7 ||
      b_status.fsm_state == ST_C9 || b_status.fsm_state == ST_C11))
    else $error("challenge timer running in a state that stops it");

  a_resp_timer_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_status.resp_on |-> !(b_status.fsm_state == ST_C0 || b_status.fsm_state == ST_C3 ||
      b_status.fsm_state == ST_C4 || b_status.fsm_state == ST_C5 ||
      b_status.fsm_state == ST_C10 || b_status.fsm_state == ST_C11))
    else $error("response timer running in a state that stops it");

  a_push_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_push && !b_pop) |=> q_valid)
    else $error("queue empty after a transaction was pushed");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_pop |=> m_axis_tvalid)
    else $error("no result after an event was executed");
`endif

endmodule

// ----- dv/testbench.sv -----
// testbench of the chap control machine: directed and random events checked by a predictor
module testbench;
  import chap_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL = 400;
  localparam logic [3:0] FN_TOP = 4'd15;
  localparam logic [7:0] NA = 8'hFF;
  // states that stop the challenge timer and the response timer
  localparam logic [11:0] CHAL_STOP = 12'b1010_1010_1111;
  localparam logic [11:0] RESP_STOP = 12'b1100_0011_1001;

  localparam logic [7:0] AUTH_RULES [NUM_EV][NUM_ST] = '{
    '{{ACT_SRCIRC, ST_C6}, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
    '{{ACT_SRCIRC, ST_C4}, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
    '{{ACT_NONE, ST_C1}, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA, NA},
    '{NA, {ACT_SRRIRR, ST_C2}, {ACT_SRRIRR, ST_C2}, {ACT_SRRIRR, ST_C2}, NA, NA,
      {ACT_SRRIRR, ST_C8}, {ACT_SRRIRR, ST_C9}, {ACT_SRRIRR, ST_C8},
      {ACT_SRRIRR, ST_C9}, {ACT_SRRIRR, ST_C8}, {ACT_SRRIRR, ST_C9}},
    '{NA, NA, {ACT_AAS, ST_C3}, NA, NA, NA, NA, NA, {ACT_NONE, ST_C10},
      {ACT_AAS, ST_C11}, NA, NA},
    '{NA, NA, {ACT_LAF, ST_C0}, NA, NA, NA, NA, NA, {ACT_LAF, ST_C0},
      {ACT_LAF, ST_C0}, NA, NA},
    '{NA, NA, NA, NA, {ACT_SRSAAS, ST_C5}, {ACT_SRS, ST_C5}, {ACT_SRS, ST_C7},
      {ACT_SRS, ST_C7}, {ACT_SRS, ST_C9}, {ACT_SRS, ST_C9}, {ACT_SRSAAS, ST_C11},
      {ACT_SRS, ST_C11}},
    '{NA, NA, NA, NA, {ACT_SRFRAF, ST_C0}, {ACT_SRFRAF, ST_C0}, {ACT_SRFRAF, ST_C0},
      {ACT_SRFRAF, ST_C0}, {ACT_SRFRAF, ST_C0}, {ACT_SRFRAF, ST_C0},
      {ACT_SRFRAF, ST_C0}, {ACT_SRFRAF, ST_C0}},
    '{NA, {ACT_NONE, ST_C1}, {ACT_SRR, ST_C2}, NA, NA, NA, {ACT_NONE, ST_C6},
      {ACT_NONE, ST_C7}, {ACT_SRR, ST_C8}, {ACT_SRR, ST_C9}, NA, NA},
    '{NA, {ACT_LAF, ST_C0}, {ACT_LAF, ST_C2}, NA, NA, NA, {ACT_LAF, ST_C0},
      {ACT_LAF, ST_C0}, {ACT_LAF, ST_C0}, {ACT_LAF, ST_C0}, {ACT_LAF, ST_C0}, NA},
    '{NA, NA, NA, NA, {ACT_SRC, ST_C4}, NA, {ACT_SRC, ST_C6}, NA, {ACT_SRC, ST_C8},
      NA, {ACT_SRC, ST_C10}, NA},
    '{NA, NA, NA, NA, {ACT_RAF, ST_C0}, NA, {ACT_RAF, ST_C0}, NA, {ACT_RAF, ST_C0},
      NA, {ACT_RAF, ST_C10}, NA},
    '{NA, NA, NA, NA, {ACT_SRCIRC, ST_C4}, {ACT_SRCIRC, ST_C4}, {ACT_SRCIRC, ST_C6},
      {ACT_SRCIRC, ST_C6}, {ACT_SRCIRC, ST_C8}, {ACT_SRCIRC, ST_C8},
      {ACT_SRCIRC, ST_C8}, {ACT_SRCIRC, ST_C10}},
    '{{ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0},
      {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0},
      {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}, {ACT_NONE, ST_C0}}
  };

  typedef enum logic [1:0] {ID_RAW, ID_CHAL, ID_RESP} id_src_e;

  typedef struct {
    logic [3:0] func;
    logic [7:0] pkt;
    logic       good;
    id_src_e    src;
  } chap_req_t;

  typedef struct packed {
    logic [3:0] state;
    logic       send_chal;
    logic       send_resp;
    logic       send_succ;
    logic       send_fail;
    logic       rep_succ;
    logic       rep_lfail;
    logic       rep_rfail;
    logic [7:0] chal_id;
    logic [7:0] resp_id;
    logic       dropped;
  } chap_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  // predictor state
  logic [7:0]  cfg_restarts = MAX_RESTARTS_RST;
  logic [15:0] cfg_period = RESTART_TICKS_RST;
  logic [3:0]  st_q = ST_C0;
  logic [7:0]  chal_id_q = '0;
  logic [7:0]  resp_id_q = '0;
  logic [7:0]  chal_retry_q = '0;
  logic [7:0]  resp_retry_q = '0;
  logic [15:0] chal_tmr_q = '0;
  logic [15:0] resp_tmr_q = '0;
  logic        chal_run_q = 1'b0;
  logic        resp_run_q = 1'b0;
  chap_outcome_t predicted;

  chap_req_t     req_backlog[$];
  chap_outcome_t due_outcomes[$];
  chap_req_t     cur_req;
  chap_outcome_t got_out;
  chap_outcome_t want_out;
  int  queued_cnt = 0;
  int  offered = 0;
  int  accepted_cnt = 0;
  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  snd_gap = 0;
  int  rcv_hold = 0;
  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  long_stall_req = 1'b0;
  bit  long_stall_done = 1'b0;

  chap_authentication_fsm i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic issue_challenge();
    chal_id_q = chal_id_q + 8'd1;
    predicted.send_chal = 1'b1;
    if (chal_retry_q != 0) chal_retry_q = chal_retry_q - 8'd1;
  endtask

  task automatic issue_response();
    predicted.send_resp = 1'b1;
    if (resp_retry_q != 0) resp_retry_q = resp_retry_q - 8'd1;
  endtask

  task automatic take_move(input logic [3:0] ev);
    logic [7:0] rule;
    logic [3:0] nxt;
    rule = NA;
    if (ev < 4'(NUM_EV) && st_q < 4'(NUM_ST)) rule = AUTH_RULES[ev][st_q];
    if (rule == NA) begin
      predicted.dropped = 1'b1;
      return;
    end
    nxt = rule[3:0];
    case (rule[7:4])
      ACT_SRCIRC: begin
        issue_challenge();
        chal_retry_q = cfg_restarts;
        chal_tmr_q = cfg_period;
        chal_run_q = 1'b1;
      end
      ACT_SRRIRR: begin
        issue_response();
        resp_retry_q = cfg_restarts;
        resp_tmr_q = cfg_period;
        resp_run_q = 1'b1;
      end
      ACT_SRS: predicted.send_succ = 1'b1;
      ACT_SRSAAS: begin
        predicted.send_succ = 1'b1;
        predicted.rep_succ = 1'b1;
      end
      ACT_SRFRAF: begin
        predicted.send_fail = 1'b1;
        predicted.rep_rfail = 1'b1;
      end
      ACT_AAS: predicted.rep_succ = 1'b1;
      ACT_LAF: predicted.rep_lfail = 1'b1;
      ACT_RAF: predicted.rep_rfail = 1'b1;
      ACT_SRR: issue_response();
      ACT_SRC: issue_challenge();
      default: ;
    endcase
    st_q = nxt;
    if (CHAL_STOP[nxt]) chal_run_q = 1'b0;
    if (RESP_STOP[nxt]) resp_run_q = 1'b0;
  endtask

  task automatic chap_step(input logic [3:0] func, input logic [7:0] pkt, input logic good);
    logic       chal_exp;
    logic       resp_exp;
    logic [3:0] ev;
    predicted = '0;
    case (func)
      FN_AUTH_BOTH:   take_move(EV_AUTH_BOTH);
      FN_AUTH_REMOTE: take_move(EV_AUTH_REMOTE);
      FN_AUTH_LOCAL:  take_move(EV_AUTH_LOCAL);
      FN_FORCE:       take_move(EV_FORCE);
      FN_CLOSE:       take_move(EV_CLOSE);
      FN_RX_CHAL: begin
        resp_id_q = pkt;
        take_move(EV_RX_CHAL);
      end
      FN_RX_SUCC: begin
        if (pkt != resp_id_q) predicted.dropped = 1'b1;
        else take_move(EV_RX_SUCC);
      end
      FN_RX_FAIL: begin
        if (pkt != resp_id_q) predicted.dropped = 1'b1;
        else take_move(EV_RX_FAIL);
      end
      FN_RX_RESP: begin
        if (pkt != chal_id_q) predicted.dropped = 1'b1;
        else take_move(good ? EV_GOOD_RESP : EV_BAD_RESP);
      end
      FN_TICK: begin
        chal_exp = chal_run_q && chal_tmr_q <= 16'd1;
        resp_exp = resp_run_q && resp_tmr_q <= 16'd1;
        if (chal_exp) begin
          if (chal_retry_q != 0) begin
            chal_tmr_q = cfg_period;
            ev = EV_CTO_PLUS;
          end else begin
            chal_run_q = 1'b0;
            ev = EV_CTO_MINUS;
          end
          if (resp_run_q && !resp_exp) resp_tmr_q = resp_tmr_q - 16'd1;
          take_move(ev);
        end else if (resp_exp) begin
          if (resp_retry_q != 0) begin
            resp_tmr_q = cfg_period;
            ev = EV_RTO_PLUS;
          end else begin
            resp_run_q = 1'b0;
            ev = EV_RTO_MINUS;
          end
          if (chal_run_q) chal_tmr_q = chal_tmr_q - 16'd1;
          take_move(ev);
        end else begin
          if (chal_run_q) chal_tmr_q = chal_tmr_q - 16'd1;
          if (resp_run_q) resp_tmr_q = resp_tmr_q - 16'd1;
        end
      end
      default: predicted.dropped = 1'b1;
    endcase
    predicted.state = st_q;
    predicted.chal_id = chal_id_q;
    predicted.resp_id = resp_id_q;
  endtask

  function automatic string show(input chap_outcome_t o);
    return $sformatf("st=%0d chal=%b resp=%b succ=%b fail=%b ok=%b lf=%b rf=%b cid=%h rid=%h ign=%b",
                     o.state, o.send_chal, o.send_resp, o.send_succ, o.send_fail, o.rep_succ,
                     o.rep_lfail, o.rep_rfail, o.chal_id, o.resp_id, o.dropped);
  endfunction

  function automatic int idle_gap(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic chap_req_t random_req();
    chap_req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.pkt = 8'($urandom);
    r.good = 1'($urandom);
    r.src = ID_RAW;
    if (pick < 34) begin
      r.func = FN_TICK;
    end else if (pick < 44) begin
      r.func = FN_RX_CHAL;
    end else if (pick < 54) begin
      r.func = FN_RX_RESP;
      r.src = ID_CHAL;
    end else if (pick < 62) begin
      r.func = FN_RX_SUCC;
      r.src = ID_RESP;
    end else if (pick < 68) begin
      r.func = FN_RX_FAIL;
      r.src = ID_RESP;
    end else if (pick < 74) begin
      r.func = 4'($urandom_range(FN_AUTH_BOTH, FN_AUTH_LOCAL));
    end else if (pick < 78) begin
      r.func = FN_FORCE;
    end else if (pick < 83) begin
      r.func = FN_CLOSE;
    end else if (pick < 95) begin
      r.func = 4'($urandom_range(FN_RX_SUCC, FN_RX_RESP));
    end else begin
      r.func = 4'($urandom_range(FN_TICK + 1, FN_TOP));
    end
    return r;
  endfunction

  task automatic push_req(input logic [3:0] f, input logic [7:0] p, input logic g,
                          input id_src_e s);
    chap_req_t r;
    r.func = f;
    r.pkt = p;
    r.good = g;
    r.src = s;
    req_backlog.push_back(r);
    queued_cnt++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_MAX_RESTARTS) cfg_restarts = value[7:0];
    else cfg_period = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    do @(negedge clk_i); while (!(accepted_cnt == queued_cnt && due_outcomes.size() == 0));
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] restarts, input logic [15:0] period,
                           input int snd_pct, input int rcv_pct, input int goal);
    chap_req_t r;
    int start;
    write_reg(REG_MAX_RESTARTS, {8'd0, restarts});
    write_reg(REG_RESTART_TICKS, period);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = queued_cnt;
    while (queued_cnt - start < goal) begin
      @(posedge clk_i);
      while (req_backlog.size() < 6 && queued_cnt - start < goal) begin
        r = random_req();
        push_req(r.func, r.pkt, r.good, r.src);
      end
      @(negedge clk_i);
    end
    settle();
  endtask

  // sender
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && accepted_cnt != offered)) begin
      if (snd_gap > 0) begin
        snd_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        cur_req = req_backlog.pop_front();
        case (cur_req.src)
          ID_CHAL: cur_req.pkt = chal_id_q;
          ID_RESP: cur_req.pkt = resp_id_q;
          default: ;
        endcase
        s_axis_tuser <= cur_req.func;
        s_axis_tdata <= {7'd0, cur_req.good, cur_req.pkt};
        s_axis_tvalid <= 1'b1;
        offered++;
        snd_gap = idle_gap(snd_idle_pct);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (rcv_hold > 0) begin
      rcv_hold--;
      m_axis_tready <= 1'b0;
    end else if (long_stall_req && !long_stall_done) begin
      long_stall_done = 1'b1;
      rcv_hold = LONG_STALL;
      m_axis_tready <= 1'b0;
    end else begin
      rcv_hold = idle_gap(rcv_idle_pct);
      m_axis_tready <= (rcv_hold == 0);
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_out.state = m_axis_tdata[3:0];
        got_out.send_chal = m_axis_tdata[4];
        got_out.send_resp = m_axis_tdata[5];
        got_out.send_succ = m_axis_tdata[6];
        got_out.send_fail = m_axis_tdata[7];
        got_out.rep_succ = m_axis_tdata[8];
        got_out.rep_lfail = m_axis_tdata[9];
        got_out.rep_rfail = m_axis_tdata[10];
        got_out.chal_id = m_axis_tdata[18:11];
        got_out.resp_id = m_axis_tdata[26:19];
        got_out.dropped = m_axis_tuser[0];
        if (due_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got_out));
        end else begin
          want_out = due_outcomes.pop_front();
          if (got_out !== want_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: %s", show(want_out));
              $display("mismatch actual:   %s", show(got_out));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        chap_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
        due_outcomes.push_back(predicted);
        accepted_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL chap_authentication_fsm");
      $finish;
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    snd_idle_pct = 30;
    rcv_idle_pct = 30;
    write_reg(REG_MAX_RESTARTS, 16'd1);
    write_reg(REG_RESTART_TICKS, 16'd2);
    // undefined code, then success with a matching id in the idle state
    push_req(FN_TOP, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_SUCC, 8'h00, 1'b0, ID_RESP);
    // authenticator: id mismatch, challenge retry, then final timeout
    push_req(FN_AUTH_BOTH, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_RESP, 8'hFF, 1'b1, ID_RAW);
    repeat (4) push_req(FN_TICK, 8'h00, 1'b0, ID_RAW);
    push_req(FN_AUTH_REMOTE, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_RESP, 8'h00, 1'b1, ID_CHAL);
    // challenge in an error entry still stores its id
    push_req(FN_RX_CHAL, 8'hA5, 1'b0, ID_RAW);
    push_req(FN_CLOSE, 8'h00, 1'b0, ID_RAW);
    // peer: response, failure, then response retry and final timeout
    push_req(FN_AUTH_LOCAL, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_CHAL, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_FAIL, 8'h00, 1'b0, ID_RESP);
    push_req(FN_AUTH_LOCAL, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_CHAL, 8'hFF, 1'b1, ID_RAW);
    repeat (4) push_req(FN_TICK, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_SUCC, 8'h00, 1'b0, ID_RESP);
    push_req(FN_FORCE, 8'h00, 1'b0, ID_RAW);
    push_req(FN_CLOSE, 8'h00, 1'b0, ID_RAW);
    push_req(FN_AUTH_BOTH, 8'h00, 1'b0, ID_RAW);
    push_req(FN_RX_RESP, 8'h00, 1'b0, ID_CHAL);
    settle();

    run_phase(8'd0, 16'd1, 20, 20, 200);
    run_phase(8'd255, 16'd3, 0, 0, 200);
    long_stall_req = 1'b1;
    run_phase(8'd2, 16'd0, 0, 10, 150);
    run_phase(8'd3, 16'hFFFF, 30, 30, 100);
    run_phase(8'd1, 16'd2, 40, 40, 250);
    run_phase(8'd4, 16'd5, 15, 25, 220);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && due_outcomes.size() == 0) begin
      $display("PASS chap_authentication_fsm");
    end else begin
      $display("FAIL chap_authentication_fsm");
    end
    $finish;
  end

endmodule

// ----- chap_authentication_fsm.f -----
hw/rtl/chap_pkg.sv
hw/rtl/chap_front.sv
hw/rtl/chap_queue.sv
hw/rtl/chap_back.sv
hw/rtl/chap_authentication_fsm.sv
dv/testbench.sv
